// ----- rtl/core/etm_pkg.sv -----
// shared types and constants of the event timestamp matcher
package etm_pkg;

  // table and ring geometry
  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_W     = $clog2(RING_DEPTH);

  // field widths
  localparam int unsigned SEC_W    = 8;
  localparam int unsigned NANOS_W  = 30;
  localparam int unsigned SUBSEC_W = 24;
  localparam int unsigned SUB_SHIFT = NANOS_W - SUBSEC_W;

  localparam logic [NANOS_W-1:0] WINDOW_RESET = NANOS_W'(10000);

  // word kinds
  localparam logic KIND_STORE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               exact;
    logic               near;
    logic [NANOS_W-1:0] best;
    logic [SLOT_W-1:0]  slot;
  } scan_tok_t;

  // slot write broadcast
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  idx;
    logic               occ;
    logic [SEC_W-1:0]   sec;
    logic [NANOS_W-1:0] nanos;
  } slot_wr_t;

  // slot clear broadcast after a hit
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
  } slot_clr_t;

endpackage

// ----- rtl/core/etm_cell.sv -----
// one slot of the timestamp table plus one stage of the search chain
module etm_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [etm_pkg::SLOT_W-1:0]        idx,
  input  etm_pkg::slot_wr_t                 wr,
  input  etm_pkg::slot_clr_t                clr,
  input  logic [etm_pkg::SEC_W-1:0]         want_sec,
  input  logic [etm_pkg::NANOS_W-1:0]       target,
  input  etm_pkg::scan_tok_t                tok_in,
  output etm_pkg::scan_tok_t                tok_out
);

  logic                          occ;
  logic [etm_pkg::SEC_W-1:0]     sec;
  logic [etm_pkg::NANOS_W-1:0]   nanos;

  logic                          sec_hit;
  logic                          sub_hit;
  logic [etm_pkg::NANOS_W-1:0]   delta;
  etm_pkg::scan_tok_t            tok_next;

  // occupancy flag, written by a store, cleared at reset and on a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (wr.en && wr.idx == idx) begin
      occ <= wr.occ;
    end else if (clr.en && clr.idx == idx) begin
      occ <= 1'b0;
    end
  end

  // stored timestamp
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == idx) begin
      sec   <= wr.sec;
      nanos <= wr.nanos;
    end
  end

  // compare against the passing request
  always_comb begin
    sec_hit = occ && (sec == want_sec);
    sub_hit = nanos[etm_pkg::NANOS_W-1:etm_pkg::SUB_SHIFT] ==
              target[etm_pkg::NANOS_W-1:etm_pkg::SUB_SHIFT];
    delta   = (nanos >= target) ? (nanos - target) : (target - nanos);

    tok_next = tok_in;
    if (tok_in.valid && !tok_in.exact) begin
      if (sec_hit && sub_hit) begin
        tok_next.exact = 1'b1;
        tok_next.slot  = idx;
      end else if (sec_hit && delta < tok_in.best) begin
        tok_next.near = 1'b1;
        tok_next.best = delta;
        tok_next.slot = idx;
      end
    end
  end

  // hand the result on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- rtl/core/event_timestamp_matcher.sv -----
// event timestamp matcher: slot table as a chain of cells with search control
//
// Input channel (in_valid / in_stall) carries one word per item. A store word
// (kind 0) writes seconds and nanoseconds into one slot; seconds of zero
// empties the slot. A store is taken while idle and gives no result.
// A request word (kind 1) sends a search token down the row of 256 slot
// cells, one cell per cycle; the result word goes from the request register
// through the 256 cells, the capture register and the output register, and
// the next word can be taken once the result is offered, so a request holds the
// input until then. The block takes no further word while a request is searching.
// Output channel (out_valid / out_stall) gives one result word per request:
// exact match first, else the nearest slot in the same second strictly
// inside match_window, else an all-zero word. A hit empties the slot and
// advances the ring position.
// A stalled result is held in the output register; the next word is taken
// meanwhile, and a finished search waits until the register frees up.
// cfg_write_en / cfg_write_data load match_window; write it only when idle.
// Reset (rst, synchronous) empties every slot, zeroes the ring position and
// loads match_window with 10000.
module event_timestamp_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [29:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  slot_index,
  input  logic [31:0] event_seconds,
  input  logic [29:0] event_nanos,
  input  logic [7:0]  want_second,
  input  logic [23:0] want_subsec,
  input  logic [15:0] event_number,
  input  logic [15:0] trigger_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic        exact_hit,
  output logic [7:0]  matched_slot,
  output logic [5:0]  ring_position,
  output logic [15:0] out_event_number,
  output logic [15:0] out_trigger_bits
);

  localparam int unsigned SW = etm_pkg::SLOT_W;
  localparam int unsigned RW = etm_pkg::RING_W;

  etm_pkg::state_t                state;
  etm_pkg::state_t                state_next;

  logic [etm_pkg::NANOS_W-1:0]    match_window;
  logic [etm_pkg::SEC_W-1:0]      want_sec;
  logic [etm_pkg::NANOS_W-1:0]    target;
  logic [15:0]                    evnum;
  logic [15:0]                    trig;
  logic [RW-1:0]                  ring_pos;

  etm_pkg::scan_tok_t             tok [etm_pkg::SLOT_COUNT+1];
  etm_pkg::scan_tok_t             res_tok;
  etm_pkg::slot_wr_t              wr;
  etm_pkg::slot_clr_t             clr;

  logic                           in_accept;
  logic                           req_accept;
  logic                           out_free;
  logic                           load_out;
  logic                           res_hit;

  assign in_accept  = in_valid && !in_stall;
  assign req_accept = in_accept && (kind == etm_pkg::KIND_REQUEST);
  assign out_free   = !out_valid || !out_stall;
  assign res_hit    = res_tok.exact || res_tok.near;

  // window register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_window <= etm_pkg::WINDOW_RESET;
    end else if (cfg_write_en) begin
      match_window <= cfg_write_data;
    end
  end

  // store broadcast to the cells
  always_comb begin
    wr.en    = in_accept && (kind == etm_pkg::KIND_STORE);
    wr.idx   = SW'(slot_index);
    wr.occ   = (event_seconds != 32'd0);
    wr.sec   = event_seconds[7:0] + 8'd1;
    wr.nanos = event_nanos;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    clr.en     = 1'b0;
    clr.idx    = res_tok.slot;
    case (state)
      etm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (req_accept) begin
          state_next = etm_pkg::ST_SCAN;
        end
      end
      etm_pkg::ST_SCAN: begin
        if (tok[etm_pkg::SLOT_COUNT].valid) begin
          state_next = etm_pkg::ST_DONE;
        end
      end
      etm_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          clr.en     = res_hit;
          state_next = etm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = etm_pkg::ST_IDLE;
      end
    endcase
  end

  // request registers and token injection
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= req_accept;
      if (req_accept) begin
        tok[0].exact <= 1'b0;
        tok[0].near  <= 1'b0;
        tok[0].best  <= match_window;
        tok[0].slot  <= '0;
        want_sec     <= want_second;
        target       <= {want_subsec, {etm_pkg::SUB_SHIFT{1'b0}}};
        evnum        <= event_number;
        trig         <= trigger_bits;
      end
    end
  end

  // row of slot cells
  for (genvar i = 0; i < etm_pkg::SLOT_COUNT; i++) begin : g_cell
    etm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (SW'(i)),
      .wr       (wr),
      .clr      (clr),
      .want_sec (want_sec),
      .target   (target),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // capture the token leaving the last cell
  always_ff @(posedge clk) begin
    if (state == etm_pkg::ST_SCAN && tok[etm_pkg::SLOT_COUNT].valid) begin
      res_tok <= tok[etm_pkg::SLOT_COUNT];
    end
  end

  // ring write position
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
    end else if (load_out && res_hit) begin
      if (ring_pos == RW'(etm_pkg::RING_DEPTH - 1)) begin
        ring_pos <= '0;
      end else begin
        ring_pos <= ring_pos + RW'(1);
      end
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload, all zero on a miss
  always_ff @(posedge clk) begin
    if (load_out) begin
      found            <= res_hit;
      exact_hit        <= res_hit && res_tok.exact;
      matched_slot     <= res_hit ? 8'(res_tok.slot) : 8'd0;
      ring_position    <= res_hit ? 6'(ring_pos) : 6'd0;
      out_event_number <= res_hit ? evnum : 16'd0;
      out_trigger_bits <= res_hit ? trig : 16'd0;
    end
  end

endmodule

// ----- tb/event_timestamp_matcher_tb.sv -----
// self-checking testbench for the event timestamp matcher: slot table, match search, ring
module event_timestamp_matcher_tb;

  localparam int SETTLE_CYCLES = 300;      // one full search plus margin
  localparam int HOLD_CYCLES   = 2000;     // long receiver hold-off
  localparam int MAX_PRINTED   = 200;
  localparam longint RUN_LIMIT = 5000000;  // time units, far past the slowest run

  // one input word as the sender sees it
  typedef struct packed {
    logic        kind;
    logic [7:0]  slot;
    logic [31:0] secs;
    logic [29:0] nanos;
    logic [7:0]  want_sec;
    logic [23:0] want_sub;
    logic [15:0] evnum;
    logic [15:0] trig;
  } event_word_t;

  // one result word
  typedef struct packed {
    logic        found;
    logic        exact;
    logic [7:0]  slot;
    logic [5:0]  ring;
    logic [15:0] evnum;
    logic [15:0] trig;
  } match_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [29:0] cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [7:0]  slot_index;
  logic [31:0] event_seconds;
  logic [29:0] event_nanos;
  logic [7:0]  want_second;
  logic [23:0] want_subsec;
  logic [15:0] event_number;
  logic [15:0] trigger_bits;
  logic        out_valid;
  logic        out_stall;
  logic        found;
  logic        exact_hit;
  logic [7:0]  matched_slot;
  logic [5:0]  ring_position;
  logic [15:0] out_event_number;
  logic [15:0] out_trigger_bits;

  // receiver stall is the per-word gap or the long hold-off
  logic rx_gap;
  logic rx_hold;
  int   hold_cycles = 0;
  assign out_stall = rx_gap | rx_hold;

  // shadow of the slot table and ring
  logic        model_occ [etm_pkg::SLOT_COUNT];
  logic [7:0]  model_sec [etm_pkg::SLOT_COUNT];
  logic [29:0] model_ns  [etm_pkg::SLOT_COUNT];
  int          ring_pos;
  logic [29:0] window;

  match_t expected_matches[$];
  int     error_count  = 0;
  int     result_count = 0;
  logic   no_idle      = 1'b0;

  event_timestamp_matcher DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .kind             (kind),
    .slot_index       (slot_index),
    .event_seconds    (event_seconds),
    .event_nanos      (event_nanos),
    .want_second      (want_second),
    .want_subsec      (want_subsec),
    .event_number     (event_number),
    .trigger_bits     (trigger_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .exact_hit        (exact_hit),
    .matched_slot     (matched_slot),
    .ring_position    (ring_position),
    .out_event_number (out_event_number),
    .out_trigger_bits (out_trigger_bits)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mismatch reporting
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               what, result_count, got, want);
  endtask

  // idle cycles drawn per word, shared by both sides
  function automatic int draw_gap();
    if (no_idle) return 0;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // store word updates the shadow table
  function automatic void record_store(input event_word_t w);
    model_occ[w.slot] = (w.secs != 32'd0);
    model_sec[w.slot] = 8'(w.secs + 32'd1);
    model_ns[w.slot]  = w.nanos;
  endfunction

  // exact pass, then nearest pass inside the window; a hit empties the slot
  function automatic match_t resolve_request(input event_word_t w);
    match_t      m;
    logic [29:0] target;
    logic [30:0] delta;
    logic [30:0] best;
    int          hit;
    m   = '0;
    hit = -1;
    for (int i = 0; i < etm_pkg::SLOT_COUNT && hit < 0; i++)
      if (model_occ[i] && model_sec[i] == w.want_sec && model_ns[i][29:6] == w.want_sub)
        hit = i;
    m.exact = (hit >= 0);
    if (hit < 0) begin
      target = {w.want_sub, 6'b0};
      best   = {1'b0, window};
      for (int i = 0; i < etm_pkg::SLOT_COUNT; i++) begin
        if (model_occ[i] && model_sec[i] == w.want_sec) begin
          delta = (model_ns[i] >= target) ? model_ns[i] - target : target - model_ns[i];
          if (delta < best) begin
            best = delta;
            hit  = i;
          end
        end
      end
    end
    if (hit >= 0) begin
      model_occ[hit] = 1'b0;
      m.found = 1'b1;
      m.slot  = 8'(hit);
      m.ring  = 6'(ring_pos);
      m.evnum = w.evnum;
      m.trig  = w.trig;
      ring_pos = (ring_pos + 1) % etm_pkg::RING_DEPTH;
    end
    return m;
  endfunction

  // random slot that currently holds an event, or -1
  function automatic int pick_occupied();
    int start;
    start = $urandom_range(0, etm_pkg::SLOT_COUNT - 1);
    for (int k = 0; k < etm_pkg::SLOT_COUNT; k++)
      if (model_occ[(start + k) % etm_pkg::SLOT_COUNT])
        return (start + k) % etm_pkg::SLOT_COUNT;
    return -1;
  endfunction

  function automatic event_word_t random_word();
    event_word_t w;
    w.kind     = ($urandom_range(0, 1) == 0) ? etm_pkg::KIND_STORE : etm_pkg::KIND_REQUEST;
    w.slot     = 8'($urandom);
    w.secs     = $urandom;
    w.nanos    = 30'($urandom_range(0, 999999999));
    w.want_sec = 8'($urandom);
    w.want_sub = 24'($urandom);
    w.evnum    = 16'($urandom);
    w.trig     = 16'($urandom);
    return w;
  endfunction

  // nanoseconds clustered around a few points so that events in one second lie close together
  function automatic logic [29:0] cluster_nanos();
    int unsigned base;
    case ($urandom_range(0, 3))
      0:       base = 0;
      1:       base = 64000;
      2:       base = 500000000;
      default: base = 999979999;
    endcase
    return 30'(base + $urandom_range(0, 20000));
  endfunction

  // random word shaped to hit stored events most of the time
  function automatic event_word_t gen_word(input int request_pct);
    event_word_t w;
    int          idx;
    int          off;
    int          sub_i;
    w = random_word();
    if ($urandom_range(0, 99) >= request_pct) begin
      w.kind = etm_pkg::KIND_STORE;
      if ($urandom_range(0, 9) < 6) w.slot = 8'($urandom_range(0, 31));
      case ($urandom_range(0, 7))
        0:       w.secs = 32'd0;
        1:       w.secs = 32'hFFFF_FFFF;
        2:       w.secs = $urandom;
        default: w.secs = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 1) == 0) w.nanos = cluster_nanos();
    end else begin
      w.kind = etm_pkg::KIND_REQUEST;
      idx = ($urandom_range(0, 9) < 6) ? pick_occupied() : -1;
      if (idx >= 0) begin
        w.want_sec = model_sec[idx];
        sub_i = int'(model_ns[idx][29:6]);
        if ($urandom_range(0, 1) == 0) begin
          off   = $urandom_range(0, 600);
          sub_i = sub_i + off - 300;
          if (sub_i < 0) sub_i = 0;
        end
        w.want_sub = 24'(sub_i);
      end else begin
        if ($urandom_range(0, 3) != 0) w.want_sec = 8'($urandom_range(2, 7));
        if ($urandom_range(0, 1) == 0) w.want_sub = 24'(cluster_nanos() >> 6);
      end
    end
    return w;
  endfunction

  // offer one word and predict its result once taken
  task automatic send_word(input event_word_t w);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind          <= w.kind;
    slot_index    <= w.slot;
    event_seconds <= w.secs;
    event_nanos   <= w.nanos;
    want_second   <= w.want_sec;
    want_subsec   <= w.want_sub;
    event_number  <= w.evnum;
    trigger_bits  <= w.trig;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (w.kind == etm_pkg::KIND_STORE) record_store(w);
    else expected_matches.push_back(resolve_request(w));
  endtask

  task automatic store_event(input logic [7:0] slot, input logic [31:0] secs,
                             input logic [29:0] nanos);
    event_word_t w;
    w = random_word();
    w.kind  = etm_pkg::KIND_STORE;
    w.slot  = slot;
    w.secs  = secs;
    w.nanos = nanos;
    send_word(w);
  endtask

  task automatic ask_match(input logic [7:0] sec, input logic [23:0] sub,
                           input logic [15:0] evnum, input logic [15:0] trig);
    event_word_t w;
    w = random_word();
    w.kind     = etm_pkg::KIND_REQUEST;
    w.want_sec = sec;
    w.want_sub = sub;
    w.evnum    = evnum;
    w.trig     = trig;
    send_word(w);
  endtask

  // stop offering, wait for every result, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [29:0] value);
    wait_drained();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    window = value;
  endtask

  // empty table, exact hits, lowest slot on a tie, slot emptied by zero seconds
  task automatic test_empty_and_exact();
    ask_match(8'd2, 24'd0, 16'hFFFF, 16'hFFFF);
    store_event(8'd0, 32'd1, 30'd0);
    ask_match(8'd2, 24'd0, 16'h0000, 16'h0000);
    store_event(8'd7, 32'd255, 30'd999999999);
    store_event(8'd255, 32'hFFFF_FFFF, 30'd999999999);
    ask_match(8'd0, 24'd15624999, 16'hA5A5, 16'h5A5A);
    ask_match(8'd0, 24'd15624999, 16'hFFFF, 16'h0000);
    ask_match(8'd0, 24'd15624999, 16'h0000, 16'hFFFF);
    store_event(8'd41, 32'd9, 30'd32000);
    store_event(8'd41, 32'd0, 30'd32000);
    ask_match(8'd10, 24'd500, 16'h1234, 16'h4321);
  endtask

  // nearest pass: tie on distance, window edge, exact beats nearer
  task automatic test_nearest_and_window();
    store_event(8'd10, 32'd100, 30'd63900);
    store_event(8'd20, 32'd100, 30'd64100);
    ask_match(8'd101, 24'd1000, 16'd1, 16'd2);
    ask_match(8'd101, 24'd1000, 16'd3, 16'd4);
    store_event(8'd30, 32'd5, 30'd74000);
    ask_match(8'd6, 24'd1000, 16'd5, 16'd6);
    store_event(8'd31, 32'd5, 30'd73999);
    ask_match(8'd6, 24'd1000, 16'd7, 16'd8);
    store_event(8'd50, 32'd77, 30'd63999);
    store_event(8'd60, 32'd77, 30'd64063);
    ask_match(8'd78, 24'd1000, 16'd9, 16'd10);
    ask_match(8'd78, 24'd1000, 16'd11, 16'd12);
    ask_match(8'd6, 24'hFF_FFFF, 16'd13, 16'd14);
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 4) == 0);
      send_word(gen_word(55));
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    wait_drained();
    hold_cycles = HOLD_CYCLES;
    for (int n = 0; n < 12; n++) send_word(gen_word(80));
    wait_drained();
  endtask

  task automatic test_window_extremes();
    write_window(30'd0);
    test_random_traffic(200);
    write_window(30'h3FFF_FFFF);
    test_random_traffic(200);
    write_window(30'd64);
    test_random_traffic(150);
    write_window(30'($urandom_range(0, 30'h3FFF_FFFF)));
    test_random_traffic(250);
    write_window(etm_pkg::WINDOW_RESET);
    test_random_traffic(150);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    match_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_matches.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = expected_matches.pop_front();
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (exact_hit !== want.exact) report_mismatch("exact_hit", exact_hit, want.exact);
        if (matched_slot !== want.slot)
          report_mismatch("matched_slot", matched_slot, want.slot);
        if (ring_position !== want.ring)
          report_mismatch("ring_position", ring_position, want.ring);
        if (out_event_number !== want.evnum)
          report_mismatch("out_event_number", out_event_number, want.evnum);
        if (out_trigger_bits !== want.trig)
          report_mismatch("out_trigger_bits", out_trigger_bits, want.trig);
      end
    end
  end

  // receiver gap per result word
  initial begin : receiver_gaps
    int gap;
    rx_gap = 1'b0;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        @(negedge clk);
        rx_gap <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      rx_gap <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // long hold-off, counted here
  initial begin : receiver_hold
    rx_hold = 1'b0;
    forever begin
      wait (hold_cycles > 0);
      @(negedge clk);
      rx_hold <= 1'b1;
      repeat (hold_cycles) @(negedge clk);
      rx_hold <= 1'b0;
      hold_cycles = 0;
    end
  end

  // run limit
  initial begin : run_limit
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // test sequence
  initial begin : run_tests
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    kind           = etm_pkg::KIND_STORE;
    slot_index     = '0;
    event_seconds  = '0;
    event_nanos    = '0;
    want_second    = '0;
    want_subsec    = '0;
    event_number   = '0;
    trigger_bits   = '0;
    window         = etm_pkg::WINDOW_RESET;
    ring_pos       = 0;
    for (int i = 0; i < etm_pkg::SLOT_COUNT; i++) begin
      model_occ[i] = 1'b0;
      model_sec[i] = '0;
      model_ns[i]  = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_exact();
    test_nearest_and_window();
    test_random_traffic(800);
    test_output_backpressure();
    test_window_extremes();
    wait_drained();

    if (expected_matches.size() != 0)
      report_mismatch("results never delivered", expected_matches.size(), 0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/etm_pkg.sv
rtl/core/etm_cell.sv
rtl/core/event_timestamp_matcher.sv
tb/event_timestamp_matcher_tb.sv
